[design/ncc_pkg.sv]
`timescale 1ns / 1ps

package ncc_pkg;

   localparam int VECTOR_LEN  = 3780;
   localparam int NUM_CLASSES = 3;
   localparam int ROWS        = 3;

   localparam int VAL_W   = 16;
   localparam int IDX_W   = 12;
   localparam int CLS_W   = 2;
   localparam int SQ_W    = 2 * VAL_W;
   localparam int SUM_W   = 44;
   localparam int ADDR_W  = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_FEATURE = 1'b1;

   localparam logic [CLS_W-1:0] CLASS_0 = 2'd0;
   localparam logic [CLS_W-1:0] CLASS_1 = 2'd1;
   localparam logic [CLS_W-1:0] CLASS_2 = 2'd2;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic              last;
      logic [VAL_W-1:0]  value;
   } feat_type;

   typedef struct packed {
      logic [CLS_W-1:0]                class_index;
      logic [ROWS-1:0][SUM_W-1:0]      sums;
   } result_type;

endpackage

[design/ncc_centroid_ram.sv]
`timescale 1ns / 1ps

module ncc_centroid_ram (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [ncc_pkg::CLS_W-1:0]              wr_row,
   input  logic [ncc_pkg::ADDR_W-1:0]             wr_addr,
   input  logic [ncc_pkg::VAL_W-1:0]              wr_data,
   input  logic                                   rd_en,
   input  logic [ncc_pkg::ADDR_W-1:0]             rd_addr,
   output logic [ncc_pkg::ROWS-1:0][ncc_pkg::VAL_W-1:0] rd_data
);

   for (genvar row = 0; row < ncc_pkg::ROWS; row++) begin : g_row
      logic [ncc_pkg::VAL_W-1:0] mem_ff [ncc_pkg::VECTOR_LEN];
      logic [ncc_pkg::VAL_W-1:0] rd_data_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_row == ncc_pkg::CLS_W'(row))) begin
            mem_ff[wr_addr] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end

      assign rd_data[row] = rd_data_ff;
   end

endmodule

[design/ncc_distance_pipe.sv]
`timescale 1ns / 1ps

module ncc_distance_pipe (
   input  logic                                          clock,
   input  logic                                          reset,
   input  ncc_pkg::feat_type                             feat,
   input  logic [ncc_pkg::ROWS-1:0][ncc_pkg::VAL_W-1:0]  cent,
   output logic                                          res_valid,
   output ncc_pkg::result_type                           res
);

   ncc_pkg::feat_type s1_ff;

   logic                                          s2_valid_ff, s2_hit_ff, s2_last_ff;
   logic [ncc_pkg::ROWS-1:0][ncc_pkg::VAL_W-1:0]  diff_in, diff_ff;

   logic                                          s3_valid_ff, s3_hit_ff, s3_last_ff;
   logic [ncc_pkg::ROWS-1:0][ncc_pkg::SQ_W-1:0]   sq_in, sq_ff;

   logic [ncc_pkg::ROWS-1:0][ncc_pkg::SUM_W-1:0]  sum_ff, sum_in, acc;
   logic                                          s4_valid_ff;
   logic [ncc_pkg::ROWS-1:0][ncc_pkg::SUM_W-1:0]  dist_ff;

   logic lt10, lt20, lt21;

   // stage 1 lines up with the memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= feat.valid;
      end
      s1_ff.hit   <= feat.hit;
      s1_ff.last  <= feat.last;
      s1_ff.value <= feat.value;
   end

   // absolute difference
   always_comb begin
      for (int r = 0; r < ncc_pkg::ROWS; r++) begin
         if (s1_ff.value >= cent[r]) begin
            diff_in[r] = s1_ff.value - cent[r];
         end else begin
            diff_in[r] = cent[r] - s1_ff.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_ff.valid;
      end
      s2_hit_ff  <= s1_ff.hit;
      s2_last_ff <= s1_ff.last;
      diff_ff    <= diff_in;
   end

   // square
   always_comb begin
      for (int r = 0; r < ncc_pkg::ROWS; r++) begin
         sq_in[r] = ncc_pkg::SQ_W'(diff_ff[r]) * ncc_pkg::SQ_W'(diff_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_hit_ff  <= s2_hit_ff;
      s3_last_ff <= s2_last_ff;
      sq_ff      <= sq_in;
   end

   // saturating accumulate, inactive rows stay at zero
   always_comb begin
      logic [ncc_pkg::SUM_W:0] wide;
      for (int r = 0; r < ncc_pkg::ROWS; r++) begin
         wide = {1'b0, sum_ff[r]} + (ncc_pkg::SUM_W + 1)'(sq_ff[r]);
         if (s3_valid_ff && s3_hit_ff && (r < ncc_pkg::NUM_CLASSES)) begin
            acc[r] = wide[ncc_pkg::SUM_W] ? ncc_pkg::SUM_MAX : wide[ncc_pkg::SUM_W-1:0];
         end else begin
            acc[r] = sum_ff[r];
         end
      end
      if (s3_valid_ff && s3_last_ff) begin
         sum_in = '0;
      end else begin
         sum_in = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         s4_valid_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         s4_valid_ff <= s3_valid_ff && s3_last_ff;
      end
      dist_ff <= acc;
   end

   // nearest class, lower index wins a tie
   assign lt10 = dist_ff[1] < dist_ff[0];
   assign lt20 = (ncc_pkg::NUM_CLASSES > 2) && (dist_ff[2] < dist_ff[0]);
   assign lt21 = (ncc_pkg::NUM_CLASSES > 2) && (dist_ff[2] < dist_ff[1]);

   always_comb begin
      res.sums = dist_ff;
      if (lt10) begin
         res.class_index = lt21 ? ncc_pkg::CLASS_2 : ncc_pkg::CLASS_1;
      end else begin
         res.class_index = lt20 ? ncc_pkg::CLASS_2 : ncc_pkg::CLASS_0;
      end
   end

   assign res_valid = s4_valid_ff;

endmodule

[design/ncc_result_queue.sv]
`timescale 1ns / 1ps

module ncc_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ncc_pkg::result_type  push_data,
   input  logic                 pop,
   output logic                 head_valid,
   output ncc_pkg::result_type  head
);

   ncc_pkg::result_type          entry_ff [ncc_pkg::QUEUE_DEPTH];
   logic [ncc_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ncc_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ncc_pkg::QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

endmodule

[design/nearest_centroid_classifier_core.sv]
`timescale 1ns / 1ps
// a result passes the stage 1, difference, square and sum registers, then the output queue
// throughput: one item per cycle while req_stall is low; centroid memory reads one element of each class per cycle
// req_stall rises while eight results are in flight or waiting in the output queue
// reset clears the running sums, pipeline valids and queue; centroid memory is not cleared
// and must be written before a vector is classified
module nearest_centroid_classifier_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [ncc_pkg::CLS_W-1:0]     req_class_sel,
   input  logic [ncc_pkg::IDX_W-1:0]     req_element_index,
   input  logic [ncc_pkg::VAL_W-1:0]     req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ncc_pkg::CLS_W-1:0]     rsp_class_index,
   output logic [ncc_pkg::SUM_W-1:0]     rsp_dist_class0,
   output logic [ncc_pkg::SUM_W-1:0]     rsp_dist_class1,
   output logic [ncc_pkg::SUM_W-1:0]     rsp_dist_class2
);

   logic                                          accept, in_range, row_ok, pop;
   logic                                          wr_en;
   ncc_pkg::feat_type                             feat;
   logic [ncc_pkg::ROWS-1:0][ncc_pkg::VAL_W-1:0]  cent;
   logic                                          res_valid;
   ncc_pkg::result_type                           res, head;
   logic [ncc_pkg::QCNT_W-1:0]                    pend_ff, pend_in;
   logic                                          inc;

   assign accept   = req_valid && !req_stall;
   assign in_range = {1'b0, req_element_index} < (ncc_pkg::IDX_W + 1)'(ncc_pkg::VECTOR_LEN);
   assign row_ok   = 32'(req_class_sel) < 32'(ncc_pkg::NUM_CLASSES);
   assign wr_en    = accept && (req_operation == ncc_pkg::OP_WRITE) && row_ok && in_range;

   always_comb begin
      feat.valid = accept && (req_operation == ncc_pkg::OP_FEATURE);
      feat.hit   = in_range;
      feat.last  = req_last;
      feat.value = req_value;
   end

   ncc_centroid_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (req_class_sel),
      .wr_addr (req_element_index[ncc_pkg::ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_en   (feat.valid && in_range),
      .rd_addr (req_element_index[ncc_pkg::ADDR_W-1:0]),
      .rd_data (cent)
   );

   ncc_distance_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .feat      (feat),
      .cent      (cent),
      .res_valid (res_valid),
      .res       (res)
   );

   ncc_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign pop = rsp_valid && !rsp_stall;
   assign inc = feat.valid && req_last;

   // results in flight plus results queued
   always_comb begin
      pend_in = pend_ff;
      if (inc && !pop) begin
         pend_in = pend_ff + 1'b1;
      end else if (pop && !inc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   assign req_stall = (pend_ff == ncc_pkg::QCNT_W'(ncc_pkg::QUEUE_DEPTH));

   assign rsp_class_index = head.class_index;
   assign rsp_dist_class0 = head.sums[0];
   assign rsp_dist_class1 = head.sums[1];
   assign rsp_dist_class2 = head.sums[2];

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam logic [ncc_pkg::CLS_W-1:0] CLASS_BAD    = 2'd3;
   localparam logic [ncc_pkg::SUM_W-1:0] FULL_SQ      = 44'd4294836225;
   localparam int                        MAX_IDX      = 4095;
   localparam int                        RANDOM_ITEMS = 1000;
   localparam int                        BURST_ITEMS  = 40;
   localparam int                        HOLD_CYCLES  = 300;
   localparam int                        MAX_REPORTS  = 10;
   localparam int                        DRAIN_CYCLES = 20;
   localparam ncc_pkg::result_type       NO_RESULT    = '0;

   typedef struct {
      logic                       op;
      logic [ncc_pkg::CLS_W-1:0]  cls;
      logic [ncc_pkg::IDX_W-1:0]  idx;
      logic [ncc_pkg::VAL_W-1:0]  val;
      logic                       last;
      bit                         typed;
      ncc_pkg::result_type        want;
   } stim_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_operation;
   logic [ncc_pkg::CLS_W-1:0]    req_class_sel;
   logic [ncc_pkg::IDX_W-1:0]    req_element_index;
   logic [ncc_pkg::VAL_W-1:0]    req_value;
   logic                         req_last;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [ncc_pkg::CLS_W-1:0]    rsp_class_index;
   logic [ncc_pkg::SUM_W-1:0]    rsp_dist_class0;
   logic [ncc_pkg::SUM_W-1:0]    rsp_dist_class1;
   logic [ncc_pkg::SUM_W-1:0]    rsp_dist_class2;

   logic [ncc_pkg::VAL_W-1:0]    centroid_rows [ncc_pkg::ROWS][ncc_pkg::VECTOR_LEN];
   logic [ncc_pkg::SUM_W-1:0]    distance_sums [ncc_pkg::ROWS];
   bit                           row_written [ncc_pkg::ROWS][ncc_pkg::VECTOR_LEN];
   bit                           idx_ready [ncc_pkg::VECTOR_LEN];
   int                           ready_indices[$];
   ncc_pkg::result_type          expected_results[$];
   stim_row_type                 directed[$];

   int                           idle_mode;
   bit                           hold_req;
   int                           fail_count;

   nearest_centroid_classifier_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_class_sel     (req_class_sel),
      .req_element_index (req_element_index),
      .req_value         (req_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_class_index   (rsp_class_index),
      .rsp_dist_class0   (rsp_dist_class0),
      .rsp_dist_class1   (rsp_dist_class1),
      .rsp_dist_class2   (rsp_dist_class2)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic ncc_pkg::result_type mk_result(input logic [ncc_pkg::CLS_W-1:0] cls,
                                                     input logic [ncc_pkg::SUM_W-1:0] d0, d1, d2);
      ncc_pkg::result_type res;
      res.class_index = cls;
      res.sums[0] = d0;
      res.sums[1] = d1;
      res.sums[2] = d2;
      return res;
   endfunction

   function automatic logic [ncc_pkg::VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end
      return ncc_pkg::VAL_W'($urandom_range(0, 65535));
   endfunction

   function automatic bit sender_idles();
      int r;
      r = $urandom_range(0, 99);
      return (idle_mode == 1 && r < 65) || (idle_mode == 3 && r < 8);
   endfunction

   function automatic bit receiver_stalls();
      int r;
      r = $urandom_range(0, 99);
      return (idle_mode == 2 && r < 65) || (idle_mode == 3 && r < 8);
   endfunction

   // model of one accepted item: centroid write, or squared distance accumulation and classification
   task automatic accumulate_item(input logic op, input logic [ncc_pkg::CLS_W-1:0] cls,
                                  input logic [ncc_pkg::IDX_W-1:0] idx,
                                  input logic [ncc_pkg::VAL_W-1:0] val,
                                  input logic last, output bit produced,
                                  output ncc_pkg::result_type res);
      logic [ncc_pkg::VAL_W-1:0] m;
      logic [ncc_pkg::VAL_W-1:0] d;
      logic [ncc_pkg::SQ_W-1:0]  sq;
      logic [ncc_pkg::SUM_W:0]   wide;
      bit                        all_set;
      int                        best;
      produced = 1'b0;
      res = NO_RESULT;
      if (op == ncc_pkg::OP_WRITE) begin
         if (cls < ncc_pkg::NUM_CLASSES && idx < ncc_pkg::VECTOR_LEN) begin
            centroid_rows[cls][idx] = val;
            row_written[cls][idx] = 1'b1;
            all_set = 1'b1;
            for (int c = 0; c < ncc_pkg::NUM_CLASSES; c++) all_set &= row_written[c][idx];
            if (all_set && !idx_ready[idx]) begin
               idx_ready[idx] = 1'b1;
               ready_indices.push_back(int'(idx));
            end
         end
      end else begin
         if (idx < ncc_pkg::VECTOR_LEN) begin
            for (int c = 0; c < ncc_pkg::NUM_CLASSES; c++) begin
               m = centroid_rows[c][idx];
               d = (val >= m) ? val - m : m - val;
               sq = ncc_pkg::SQ_W'(d) * ncc_pkg::SQ_W'(d);
               wide = {1'b0, distance_sums[c]} + (ncc_pkg::SUM_W + 1)'(sq);
               distance_sums[c] = wide[ncc_pkg::SUM_W] ? ncc_pkg::SUM_MAX
                                                       : wide[ncc_pkg::SUM_W-1:0];
            end
         end
         if (last) begin
            best = 0;
            for (int c = 1; c < ncc_pkg::NUM_CLASSES; c++) begin
               if (distance_sums[c] < distance_sums[best]) best = c;
            end
            produced = 1'b1;
            res.class_index = ncc_pkg::CLS_W'(best);
            for (int c = 0; c < ncc_pkg::ROWS; c++) begin
               res.sums[c] = (c < ncc_pkg::NUM_CLASSES) ? distance_sums[c] : '0;
               distance_sums[c] = '0;
            end
         end
      end
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic op, input logic [ncc_pkg::CLS_W-1:0] cls,
                            input logic [ncc_pkg::IDX_W-1:0] idx,
                            input logic [ncc_pkg::VAL_W-1:0] val,
                            input logic last, input bit typed,
                            input ncc_pkg::result_type want);
      bit                  produced;
      ncc_pkg::result_type predicted;
      while (sender_idles()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_class_sel = cls;
      req_element_index = idx;
      req_value = val;
      req_last = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_item(op, cls, idx, val, last, produced, predicted);
      if (produced) expected_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [ncc_pkg::SUM_W-1:0] want_v,
                                  input logic [ncc_pkg::SUM_W-1:0] got_v);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
      end
   endtask

   // receiver: random stall, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall = receiver_stalls();
      end
   end

   always @(posedge clock) begin : check_results
      ncc_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("result with no item pending: class %0d", rsp_class_index);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_class_index !== want.class_index) begin
               report_mismatch("class_index", ncc_pkg::SUM_W'(want.class_index),
                               ncc_pkg::SUM_W'(rsp_class_index));
            end
            if (rsp_dist_class0 !== want.sums[0]) begin
               report_mismatch("dist_class0", want.sums[0], rsp_dist_class0);
            end
            if (rsp_dist_class1 !== want.sums[1]) begin
               report_mismatch("dist_class1", want.sums[1], rsp_dist_class1);
            end
            if (rsp_dist_class2 !== want.sums[2]) begin
               report_mismatch("dist_class2", want.sums[2], rsp_dist_class2);
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("nearest_centroid_classifier_core test failed");
      $finish;
   end

   initial begin
      int                         sent;
      int                         pick;
      int                         len;
      int                         idx_pick;
      logic [ncc_pkg::IDX_W-1:0]  idx_el;
      stim_row_type               row;

      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = ncc_pkg::OP_WRITE;
      req_class_sel = '0;
      req_element_index = '0;
      req_value = '0;
      req_last = 1'b0;
      idle_mode = 0;
      hold_req = 1'b0;
      fail_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_0, 12'd0, 16'h0000, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_1, 12'd0, 16'hFFFF, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_2, 12'd0, 16'h0000, 1'b0, 1'b0,
                           NO_RESULT});
      // write to a missing row, then a write past the vector with last set
      directed.push_back('{ncc_pkg::OP_WRITE, CLASS_BAD, 12'd0, 16'h007B, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_0, 12'd4095, 16'h0007, 1'b1, 1'b0,
                           NO_RESULT});
      // tie between class 0 and class 2
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_0, 12'd0, 16'h0000, 1'b1, 1'b1,
                           mk_result(ncc_pkg::CLASS_0, '0, FULL_SQ, '0)});
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_0, 12'd0, 16'hFFFF, 1'b1, 1'b1,
                           mk_result(ncc_pkg::CLASS_1, FULL_SQ, '0, FULL_SQ)});
      // element past the vector still closes it
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_0, 12'd4095, 16'hFFFF, 1'b1,
                           1'b1, mk_result(ncc_pkg::CLASS_0, '0, '0, '0)});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_0, 12'd1, 16'h8000, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_1, 12'd1, 16'h8000, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_2, 12'd1, 16'h0000, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_0, 12'd3779, 16'hFFFF, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_1, 12'd3779, 16'h0000, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_2, 12'd3779, 16'hFFFF, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_WRITE, ncc_pkg::CLASS_2, 12'd3780, 16'h1234, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_1, 12'd1, 16'h0000, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_2, 12'd3779, 16'h0000, 1'b1,
                           1'b0, NO_RESULT});
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_0, 12'd3780, 16'h0001, 1'b0,
                           1'b0, NO_RESULT});
      directed.push_back('{ncc_pkg::OP_FEATURE, CLASS_BAD, 12'd1, 16'hFFFF, 1'b1, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_0, 12'd0, 16'h5555, 1'b0, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_0, 12'd0, 16'hAAAA, 1'b1, 1'b0,
                           NO_RESULT});
      directed.push_back('{ncc_pkg::OP_FEATURE, ncc_pkg::CLASS_0, 12'd0, 16'h8000, 1'b1, 1'b0,
                           NO_RESULT});

      foreach (directed[i]) begin
         idle_mode = i % 4;
         row = directed[i];
         send_item(row.op, row.cls, row.idx, row.val, row.last, row.typed, row.want);
      end

      // one-element vectors back to back while the receiver holds off
      idle_mode = 0;
      hold_req = 1'b1;
      repeat (BURST_ITEMS) begin
         idx_pick = ready_indices[$urandom_range(0, ready_indices.size() - 1)];
         send_item(ncc_pkg::OP_FEATURE, ncc_pkg::CLS_W'($urandom_range(0, 3)),
                   ncc_pkg::IDX_W'(idx_pick), pick_value(), 1'b1, 1'b0, NO_RESULT);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_mode = (sent / 100) % 4;
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            idx_pick = $urandom_range(0, ncc_pkg::VECTOR_LEN - 1);
            for (int c = 0; c < ncc_pkg::NUM_CLASSES; c++) begin
               send_item(ncc_pkg::OP_WRITE, ncc_pkg::CLS_W'(c), ncc_pkg::IDX_W'(idx_pick),
                         pick_value(), 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
            end
            sent += ncc_pkg::NUM_CLASSES;
         end else if (pick < 25) begin
            send_item(ncc_pkg::OP_WRITE, ncc_pkg::CLS_W'($urandom_range(0, 3)),
                      ncc_pkg::IDX_W'($urandom_range(0, MAX_IDX)),
                      ncc_pkg::VAL_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      1'b0, NO_RESULT);
            sent++;
         end else begin
            len = $urandom_range(1, 12);
            for (int e = 0; e < len; e++) begin
               if ($urandom_range(0, 9) == 0) begin
                  idx_el = ncc_pkg::IDX_W'($urandom_range(ncc_pkg::VECTOR_LEN, MAX_IDX));
               end else begin
                  idx_el = ncc_pkg::IDX_W'(
                     ready_indices[$urandom_range(0, ready_indices.size() - 1)]);
               end
               send_item(ncc_pkg::OP_FEATURE, ncc_pkg::CLS_W'($urandom_range(0, 3)), idx_el,
                         pick_value(), e == len - 1, 1'b0, NO_RESULT);
            end
            sent += len;
         end
      end

      req_valid = 1'b0;
      idle_mode = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("nearest_centroid_classifier_core test passed");
      end else begin
         $display("nearest_centroid_classifier_core test failed");
      end
      $finish;
   end

endmodule
